>>> rtl/assert_macros.svh
// Assertion macros shared by the downsampler RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds on every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/yuvds_pkg.sv
// Shared types and constants of the 4:4:4 to 4:2:0 downsampler.
// Used by yuvds_front, yuvds_emit and the top level; depends on nothing.
`timescale 1ns / 1ps

package yuvds_pkg;

    localparam logic [2:0] CFG_LINE_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_LUMA_STRIDE   = 3'd1;
    localparam logic [2:0] CFG_CHROMA_STRIDE = 3'd2;
    localparam logic [2:0] CFG_OUTPUT_MODE   = 3'd3;
    localparam logic [2:0] CFG_START_ROW     = 3'd4;
    localparam logic [2:0] CFG_END_ROW       = 3'd5;

    localparam logic [12:0] ROW_MAX = 13'h1FFF;

    typedef enum logic [1:0] {
        PLANE_LUMA = 2'd0,
        PLANE_U    = 2'd1,
        PLANE_V    = 2'd2,
        PLANE_UV   = 2'd3
    } t_plane;

    typedef struct packed {
        logic [12:0] line_width;
        logic [15:0] luma_stride;
        logic [15:0] chroma_stride;
        logic        output_mode;
        logic [11:0] start_row;
        logic [12:0] end_row;
    } t_cfg;

    typedef struct packed {
        logic [12:0] row;
        logic [12:0] col;
        logic [7:0]  luma;
        logic [8:0]  u_sum;
        logic [8:0]  v_sum;
        logic        chroma;
    } t_pix;

endpackage

>>> rtl/yuvds_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module yuvds_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/yuvds_front.sv
// Input stage: pixel position tracking, row-pair chroma sums and line store access.
// Depends on yuvds_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yuvds_front #(
    parameter int MAX_WIDTH = 4096,
    localparam int DEPTH = MAX_WIDTH / 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  yuvds_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [23:0]       i_data,   // u_sample, luma_in, v_sample
    input  logic              i_first,
    input  logic              i_take,
    output logic              o_s1_vld,
    output yuvds_pkg::t_pix   o_s1,
    output logic              o_mem_we,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_addr,
    output logic [17:0]       o_mem_wdata
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [13:0] MAXW      = 14'(MAX_WIDTH);
    localparam logic [13:0] MAXW_EVEN = 14'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [12:0] IDX_MASK  = 13'(DEPTH - 1);

    logic [CW-1:0]   r_col, n_col;
    logic [12:0]     r_row, n_row;
    logic [7:0]      r_held_u, r_held_v;
    logic            r_s1_vld;
    yuvds_pkg::t_pix r_s1, n_s1;

    logic [13:0] lw_even, width, c_base, c_cur, c_inc;
    logic        wrap, acc, in_range, is_odd, second;
    logic [12:0] row_cur;
    logic [7:0]  u_in, y_in, v_in;
    logic [8:0]  us9, vs9;

    assign u_in = i_data[7:0];
    assign y_in = i_data[15:8];
    assign v_in = i_data[23:16];

    assign acc     = i_valid && o_ready;
    assign o_ready = !r_s1_vld || i_take;

    assign lw_even = {1'b0, i_cfg.line_width[12:1], 1'b0};

    always_comb begin
        if (lw_even < 14'd2) begin
            width = 14'd2;
        end else if (lw_even > MAXW) begin
            width = MAXW_EVEN;
        end else begin
            width = lw_even;
        end
    end

    assign c_base  = i_first ? 14'd0 : 14'(r_col);
    assign c_cur   = (c_base >= width) ? 14'd0 : c_base;
    assign c_inc   = c_cur + 14'd1;
    assign wrap    = (c_inc >= width);
    assign row_cur = i_first ? {1'b0, i_cfg.start_row} : r_row;

    assign n_col = wrap ? '0 : CW'(c_inc);
    assign n_row = (wrap && (row_cur != yuvds_pkg::ROW_MAX)) ? row_cur + 13'd1 : row_cur;

    assign in_range = (row_cur >= {1'b0, i_cfg.start_row}) && (row_cur < i_cfg.end_row);
    assign is_odd   = c_cur[0];
    assign second   = row_cur[0];

    assign us9 = 9'(r_held_u) + 9'(u_in);
    assign vs9 = 9'(r_held_v) + 9'(v_in);

    assign o_mem_we    = acc && in_range && is_odd && !second;
    assign o_mem_re    = acc && in_range && is_odd && second;
    assign o_mem_addr  = AW'(c_cur[13:1] & IDX_MASK);
    assign o_mem_wdata = {us9, vs9};

    always_comb begin
        n_s1.row    = row_cur;
        n_s1.col    = c_cur[12:0];
        n_s1.luma   = y_in;
        n_s1.u_sum  = us9;
        n_s1.v_sum  = vs9;
        n_s1.chroma = is_odd && second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_held_u <= '0;
            r_held_v <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_s1_vld <= in_range;
                if (in_range && !is_odd) begin
                    r_held_u <= u_in;
                    r_held_v <= v_in;
                end
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_vld = r_s1_vld;
    assign o_s1     = r_s1;

    `ASSERT_ALWAYS(a_no_rw_clash, !(o_mem_we && o_mem_re), "line store read and write together")
    `ASSERT_NEXT(a_drop_no_stage, acc && !in_range, !r_s1_vld, "dropped pixel entered stage")

endmodule

>>> rtl/yuvds_emit.sv
// Output stage: 2x2 averages, plane offsets and serialization of results.
// Depends on yuvds_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yuvds_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  yuvds_pkg::t_cfg i_cfg,
    input  logic            i_s1_vld,
    input  yuvds_pkg::t_pix i_s1,
    input  logic [17:0]     i_rdata,
    output logic            o_take,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [47:0]     o_tdata,  // byte_offset, first_byte, second_byte, byte_count
    output logic [1:0]      o_tuser,  // plane
    output logic            o_tlast
);

    localparam logic [1:0] RES_LUMA   = 2'd0;
    localparam logic [1:0] RES_CHROMA = 2'd1;
    localparam logic [1:0] RES_V      = 2'd2;

    logic        r_s2_vld;
    logic [1:0]  r_s2_idx;
    logic [23:0] r_luma_prod, r_chroma_prod;
    logic [12:0] r_col;
    logic [7:0]  r_y, r_u, r_v;
    logic        r_chroma;

    logic             r_out_vld;
    logic [23:0]      r_out_off;
    logic [7:0]       r_out_first, r_out_second;
    logic [1:0]       r_out_cnt;
    yuvds_pkg::t_plane r_out_plane;
    logic             r_out_last;

    logic [28:0] luma_prod;
    logic [27:0] chroma_prod;
    logic [9:0]  u_tot, v_tot;
    logic [23:0] half_off, pair_off;

    yuvds_pkg::t_plane res_plane;
    logic [23:0]       res_off;
    logic [7:0]        res_first, res_second;
    logic [1:0]        res_cnt;
    logic              res_last;
    logic              out_load;

    assign luma_prod   = i_s1.row * i_cfg.luma_stride;
    assign chroma_prod = i_s1.row[12:1] * i_cfg.chroma_stride;
    assign u_tot       = 10'(i_s1.u_sum) + 10'(i_rdata[17:9]);
    assign v_tot       = 10'(i_s1.v_sum) + 10'(i_rdata[8:0]);

    assign half_off = 24'(r_col[12:1]);
    assign pair_off = 24'({r_col[12:1], 1'b0});

    always_comb begin
        res_plane  = yuvds_pkg::PLANE_LUMA;
        res_off    = r_luma_prod + 24'(r_col);
        res_first  = r_y;
        res_second = 8'd0;
        res_cnt    = 2'd1;
        res_last   = !r_chroma;
        case (r_s2_idx)
            RES_LUMA: begin
                res_plane = yuvds_pkg::PLANE_LUMA;
            end
            RES_CHROMA: begin
                res_first = r_u;
                if (i_cfg.output_mode) begin
                    res_plane  = yuvds_pkg::PLANE_UV;
                    res_off    = r_chroma_prod + pair_off;
                    res_second = r_v;
                    res_cnt    = 2'd2;
                    res_last   = 1'b1;
                end else begin
                    res_plane = yuvds_pkg::PLANE_U;
                    res_off   = r_chroma_prod + half_off;
                    res_last  = 1'b0;
                end
            end
            RES_V: begin
                res_plane = yuvds_pkg::PLANE_V;
                res_off   = r_chroma_prod + half_off;
                res_first = r_v;
                res_last  = 1'b1;
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    assign out_load = r_s2_vld && (!r_out_vld || i_tready);
    assign o_take   = !r_s2_vld || (out_load && res_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s2_idx  <= RES_LUMA;
            r_out_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_s2_vld <= i_s1_vld;
                r_s2_idx <= RES_LUMA;
            end else if (out_load) begin
                r_s2_idx <= r_s2_idx + 2'd1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_s1_vld) begin
            r_luma_prod   <= luma_prod[23:0];
            r_chroma_prod <= chroma_prod[23:0];
            r_col         <= i_s1.col;
            r_y           <= i_s1.luma;
            r_u           <= u_tot[9:2];
            r_v           <= v_tot[9:2];
            r_chroma      <= i_s1.chroma;
        end
        if (out_load) begin
            r_out_off    <= res_off;
            r_out_first  <= res_first;
            r_out_second <= res_second;
            r_out_cnt    <= res_cnt;
            r_out_plane  <= res_plane;
            r_out_last   <= res_last;
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = {6'd0, r_out_cnt, r_out_second, r_out_first, r_out_off};
    assign o_tuser  = r_out_plane;
    assign o_tlast  = r_out_last;

    `ASSERT_IMPLIES(a_take_on_last, r_s2_vld && o_take, out_load && res_last,
        "pixel released before its last result")
    `ASSERT_IMPLIES(a_v_only_planar, r_s2_vld && (r_s2_idx == RES_V),
        r_chroma && !i_cfg.output_mode, "V plane result outside planar chroma")

endmodule

>>> rtl/packed_yuv444_to_420_downsampler.sv
// Converts packed 4:4:4 pixels, one per item, into planar 4:2:0 byte writes. Each
// accepted pixel yields its luma write; the pixel that closes a 2x2 block (odd column
// of an odd row) also yields the averaged chroma, as separate U and V writes or as one
// interleaved UV write. A pixel is accepted every cycle while the output keeps up;
// results leave at one per cycle while the output is ready, so a block-closing pixel
// yields three results (planar) or two (interleaved) and holds off the input until its
// last result is loaded. Each pixel passes the s1, s2 and output registers. First-row
// pair sums live in a MAX_WIDTH/2 x 18 line store with one access per cycle; it needs
// no clearing pass. Rows outside start_row..end_row-1 are counted and produce nothing.
`timescale 1ns / 1ps

module packed_yuv444_to_420_downsampler #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // u_sample, luma_in, v_sample
    input  logic [0:0]  s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // byte_offset, first_byte, second_byte, byte_count
    output logic [1:0]  m_axis_tuser,   // plane
    output logic        m_axis_tlast
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    yuvds_pkg::t_cfg r_cfg;
    yuvds_pkg::t_pix s1;
    logic            s1_vld, take;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_addr;
    logic [17:0]     mem_wdata, mem_rdata;
    logic            cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width    <= 13'd1920;
            r_cfg.luma_stride   <= 16'd1920;
            r_cfg.chroma_stride <= 16'd960;
            r_cfg.output_mode   <= 1'b0;
            r_cfg.start_row     <= 12'd0;
            r_cfg.end_row       <= 13'd1080;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                yuvds_pkg::CFG_LINE_WIDTH:    r_cfg.line_width    <= i_cfg_data[12:0];
                yuvds_pkg::CFG_LUMA_STRIDE:   r_cfg.luma_stride   <= i_cfg_data;
                yuvds_pkg::CFG_CHROMA_STRIDE: r_cfg.chroma_stride <= i_cfg_data;
                yuvds_pkg::CFG_OUTPUT_MODE:   r_cfg.output_mode   <= i_cfg_data[0];
                yuvds_pkg::CFG_START_ROW:     r_cfg.start_row     <= i_cfg_data[11:0];
                yuvds_pkg::CFG_END_ROW:       r_cfg.end_row       <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    yuvds_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_first     (s_axis_tuser[0]),
        .i_take      (take),
        .o_s1_vld    (s1_vld),
        .o_s1        (s1),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    yuvds_ram #(
        .WIDTH (18),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    yuvds_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_s1_vld (s1_vld),
        .i_s1     (s1),
        .i_rdata  (mem_rdata),
        .o_take   (take),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
